### sv/cxy_pkg.sv
package cxy_pkg;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned CNT_W  = 17;
    localparam int unsigned ERR_W  = 18;
    localparam int unsigned HP_W   = 25;
    localparam int unsigned ALU_W  = 32;

    localparam logic [15:0] SPEED_MIN = 16'd100;
    localparam logic [15:0] SPEED_MAX = 16'd5000;
    localparam logic [31:0] HP_NUM_MAX = 32'd30000000;
    localparam logic [31:0] HP_NUM_MIN = 32'd3000000000;

    // register indexes
    localparam logic [1:0] REG_TRAVEL_LIM = 2'd0;
    localparam logic [1:0] REG_SPR        = 2'd1;
    localparam logic [1:0] REG_ACCEL      = 2'd2;

    // result status codes
    localparam logic [2:0] ST_STARTED  = 3'd0;
    localparam logic [2:0] ST_AT_LIMIT = 3'd1;
    localparam logic [2:0] ST_STEPPING = 3'd2;
    localparam logic [2:0] ST_DONE     = 3'd3;
    localparam logic [2:0] ST_ABORTED  = 3'd4;
    localparam logic [2:0] ST_LIMIT    = 3'd5;
    localparam logic [2:0] ST_IDLE     = 3'd6;

    typedef enum logic {
        ALU_DIV,
        ALU_MUL
    } alu_op_t;

    typedef struct packed {
        logic              go;
        alu_op_t           op;
        logic [ALU_W-1:0]  a;
        logic [ALU_W-1:0]  b;
    } alu_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PLAN,
        S_DIV_RAMP,
        S_DIV_MAX,
        S_DIV_MIN,
        S_DIV_SLOPE,
        S_MUL,
        S_EMIT
    } fsm_state_t;

endpackage

### sv/cxy_alu.sv
// Shared bit-serial unit: restoring divide or shift-add multiply, one bit a cycle
module cxy_alu
    import cxy_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  alu_req_t         req,
    output logic             done,
    output logic [ALU_W-1:0] res
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    alu_op_t          op_reg, op_next;
    logic [ALU_W-1:0] a_reg, a_next;
    logic [ALU_W-1:0] b_reg, b_next;
    logic [ALU_W:0]   acc_reg, acc_next;
    logic [ALU_W:0]   trial;

    // one iteration
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        trial     = {acc_reg[ALU_W-1:0], a_reg[ALU_W-1]};
        if (req.go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = req.op;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                ALU_DIV:
                begin
                    if (trial >= {1'b0, b_reg})
                    begin
                        acc_next = trial - {1'b0, b_reg};
                        a_next   = {a_reg[ALU_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = trial;
                        a_next   = {a_reg[ALU_W-2:0], 1'b0};
                    end
                end
                ALU_MUL:
                begin
                    if (a_reg[0])
                        acc_next = acc_reg + {1'b0, b_reg};
                    a_next = {1'b0, a_reg[ALU_W-1:1]};
                    b_next = {b_reg[ALU_W-2:0], 1'b0};
                end
                default: ;
            endcase
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign res  = (op_reg == ALU_DIV) ? a_reg : acc_reg[ALU_W-1:0];

    a_no_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.go) else $error("request while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == 5'd31 && !req.go) |=> done_reg)
        else $error("missing done");

endmodule

### sv/corexy_stepper_move_generator.sv
// CoreXY move generator with a linear speed ramp.
// Input stream s_axis: tuser carries func (0 start, 1 tick); tdata carries the
// move request and the tick flags. Output stream m_axis gives exactly one
// result item per input item. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_wdata); a zero value is stored as one.
// One input item is worked on at a time; s_axis_tready is low meanwhile.
// Work per item: a start that is not at the limit runs four serial divisions
// in the shared bit-serial unit (ramp length, max and min half period,
// slope); a moving tick runs one serial multiply of slope by ramp offset;
// an idle, abort or limit tick, and a start at the limit, use no unit.
// A new item is taken while the previous result still waits, provided the
// receiver takes it in that same cycle; if m_axis_tready stays low the
// result is held and no further item is accepted.
// Reset clears position, move state and the result valid flag, and loads the
// registers with a 10000 step travel limit, 1600 microsteps per revolution
// and accel 20.
module corexy_stepper_move_generator
    import cxy_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // delta_x[16:0], delta_y[33:17], speed_centi_rpm[49:34],
    // limit_hit[50], abort_request[51], zero fill
    input  logic [55:0] s_axis_tdata,
    // func
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // step_mask[1:0], dir_one[2], dir_two[3], half_period_us[28:4],
    // pos_x[44:29], pos_y[60:45], status[63:61]
    output logic [63:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    fsm_state_t state_reg, state_next;

    logic [15:0] travel_lim_reg, spr_reg, accel_reg;
    logic [15:0] cfg_val;

    logic             func_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [15:0]      speed_reg;
    logic             limit_reg, abort_reg;

    logic [POS_W-1:0] px_reg, py_reg, tx_reg, ty_reg;
    logic [1:0]       dirs_reg;
    logic [CNT_W-1:0] cnt0_reg, cnt1_reg, done0_reg, done1_reg;
    logic [ERR_W-1:0] err0_reg, err1_reg;
    logic [CNT_W-1:0] tot_reg, idx_reg, ramp_reg;
    logic [HP_W-1:0]  mind_reg, maxd_reg, slope_reg;
    logic             moving_reg;
    logic [31:0]      prod_reg;
    logic             up_reg;

    logic [1:0]       res_mask_reg;
    logic [HP_W-1:0]  res_hp_reg;
    logic [2:0]       res_st_reg;
    logic             ovalid_reg;
    logic [63:0]      odata_reg;

    alu_req_t         alu_req;
    logic             alu_done;
    logic [ALU_W-1:0] alu_res;

    logic accept;

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [19:0] v,
                                                   input logic [15:0] lim);
        logic [POS_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({4'b0, lim}))
            r = lim;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    cxy_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .done  (alu_done),
        .res   (alu_res)
    );

    assign accept = s_axis_tvalid && s_axis_tready;
    assign cfg_val = (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;

    // partial stop: signed motor progress back to X/Y
    logic signed [17:0] s1, s2;
    logic signed [18:0] ssum, sdif;
    logic signed [18:0] hsum, hdif;
    logic [POS_W-1:0]   stop_x, stop_y;
    always_comb
    begin
        s1 = dirs_reg[0] ? $signed({1'b0, done0_reg}) : -$signed({1'b0, done0_reg});
        s2 = dirs_reg[1] ? $signed({1'b0, done1_reg}) : -$signed({1'b0, done1_reg});
        ssum = 19'(s1) + 19'(s2);
        sdif = 19'(s1) - 19'(s2);
        hsum = (ssum + $signed({18'd0, ssum[18]})) >>> 1;
        hdif = (sdif + $signed({18'd0, sdif[18]})) >>> 1;
        stop_x = clamp_pos($signed({4'b0, px_reg}) + 20'(hsum), travel_lim_reg);
        stop_y = clamp_pos($signed({4'b0, py_reg}) + 20'(hdif), travel_lim_reg);
    end

    // move planning
    logic [15:0]        speed_c;
    logic [POS_W-1:0]   tgt_x, tgt_y;
    logic signed [16:0] rdx, rdy;
    logic signed [17:0] m1, m2;
    logic [CNT_W-1:0]   a1, a2, tot_c;
    logic               at_limit;
    always_comb
    begin
        if (speed_reg < SPEED_MIN)
            speed_c = SPEED_MIN;
        else if (speed_reg > SPEED_MAX)
            speed_c = SPEED_MAX;
        else
            speed_c = speed_reg;
        tgt_x = clamp_pos($signed({4'b0, px_reg}) + 20'(dx_reg), travel_lim_reg);
        tgt_y = clamp_pos($signed({4'b0, py_reg}) + 20'(dy_reg), travel_lim_reg);
        rdx = $signed({1'b0, tgt_x}) - $signed({1'b0, px_reg});
        rdy = $signed({1'b0, tgt_y}) - $signed({1'b0, py_reg});
        m1  = -18'(rdx) + 18'(rdy);
        m2  = -18'(rdx) - 18'(rdy);
        a1  = m1[17] ? CNT_W'(-m1) : m1[CNT_W-1:0];
        a2  = m2[17] ? CNT_W'(-m2) : m2[CNT_W-1:0];
        tot_c = (a1 > a2) ? a1 : a2;
        at_limit = (rdx == 0) && (rdy == 0);
    end

    // ramp length from the quotient
    logic [CNT_W-1:0] ramp_c;
    logic [CNT_W-1:0] half_tot;
    always_comb
    begin
        half_tot = tot_reg >> 1;
        if (alu_res[31:CNT_W] != '0 || alu_res[CNT_W-1:0] >= half_tot)
            ramp_c = half_tot;
        else
            ramp_c = alu_res[CNT_W-1:0];
        if (ramp_c == '0)
            ramp_c = CNT_W'(1);
    end

    // tick: ramp phase and Bresenham step
    logic [CNT_W-1:0] down_start, ramp_off;
    logic             in_up, in_down;
    logic [ERR_W-1:0] e0, e1;
    logic             p0, p1;
    logic [CNT_W-1:0] idx_inc;
    logic [HP_W-1:0]  hp_c;
    always_comb
    begin
        down_start = tot_reg - ramp_reg;
        in_up   = idx_reg < ramp_reg;
        in_down = !in_up && (idx_reg >= down_start);
        if (in_up)
            ramp_off = idx_reg;
        else if (in_down)
            ramp_off = idx_reg - down_start;
        else
            ramp_off = '0;
        e0 = err0_reg + ERR_W'(cnt0_reg);
        e1 = err1_reg + ERR_W'(cnt1_reg);
        p0 = e0 >= ERR_W'(tot_reg);
        p1 = e1 >= ERR_W'(tot_reg);
        idx_inc = idx_reg + CNT_W'(1);
        hp_c = up_reg ? maxd_reg - alu_res[HP_W-1:0] : mind_reg + alu_res[HP_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (accept) state_next = S_DECODE;
            S_DECODE:
            begin
                if (!func_reg)
                    state_next = S_PLAN;
                else if (!moving_reg || abort_reg || limit_reg)
                    state_next = S_EMIT;
                else
                    state_next = S_MUL;
            end
            S_PLAN:      state_next = at_limit ? S_EMIT : S_DIV_RAMP;
            S_DIV_RAMP:  if (alu_done) state_next = S_DIV_MAX;
            S_DIV_MAX:   if (alu_done) state_next = S_DIV_MIN;
            S_DIV_MIN:   if (alu_done) state_next = S_DIV_SLOPE;
            S_DIV_SLOPE: if (alu_done) state_next = S_EMIT;
            S_MUL:       if (alu_done) state_next = S_EMIT;
            S_EMIT:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs: shared unit requests and handshake
    always_comb
    begin
        alu_req = '{go: 1'b0, op: ALU_DIV, a: '0, b: '0};
        s_axis_tready = (state_reg == S_IDLE) && (!ovalid_reg || m_axis_tready);
        unique case (state_reg)
            S_DECODE:
            begin
                if (func_reg && moving_reg && !abort_reg && !limit_reg)
                    alu_req = '{go: 1'b1, op: ALU_MUL,
                                a: {15'd0, ramp_off}, b: {7'd0, slope_reg}};
            end
            S_PLAN:
            begin
                if (!at_limit)
                    alu_req = '{go: 1'b1, op: ALU_DIV,
                                a: {16'd0, speed_c - SPEED_MIN}, b: {16'd0, accel_reg}};
            end
            S_DIV_RAMP:
            begin
                if (alu_done)
                    alu_req = '{go: 1'b1, op: ALU_DIV, a: HP_NUM_MAX, b: {16'd0, spr_reg}};
            end
            S_DIV_MAX:
            begin
                if (alu_done)
                    alu_req = '{go: 1'b1, op: ALU_DIV, a: HP_NUM_MIN, b: prod_reg};
            end
            S_DIV_MIN:
            begin
                if (alu_done)
                    alu_req = '{go: 1'b1, op: ALU_DIV,
                                a: {7'd0, maxd_reg - alu_res[HP_W-1:0]},
                                b: {15'd0, ramp_reg}};
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            travel_lim_reg <= 16'd10000;
            spr_reg        <= 16'd1600;
            accel_reg      <= 16'd20;
            px_reg         <= '0;
            py_reg         <= '0;
            tx_reg         <= '0;
            ty_reg         <= '0;
            dirs_reg       <= '0;
            cnt0_reg       <= '0;
            cnt1_reg       <= '0;
            err0_reg       <= '0;
            err1_reg       <= '0;
            done0_reg      <= '0;
            done1_reg      <= '0;
            tot_reg        <= '0;
            idx_reg        <= '0;
            ramp_reg       <= '0;
            mind_reg       <= '0;
            maxd_reg       <= '0;
            slope_reg      <= '0;
            moving_reg     <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TRAVEL_LIM: travel_lim_reg <= cfg_val;
                    REG_SPR:        spr_reg        <= cfg_val;
                    REG_ACCEL:      accel_reg      <= cfg_val;
                    default: ;
                endcase
            end
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_DECODE:
                begin
                    if (moving_reg && (!func_reg || abort_reg || limit_reg))
                    begin
                        px_reg     <= stop_x;
                        py_reg     <= stop_y;
                        moving_reg <= 1'b0;
                    end
                end
                S_PLAN:
                begin
                    tx_reg <= tgt_x;
                    ty_reg <= tgt_y;
                    if (!at_limit)
                    begin
                        dirs_reg  <= {!m2[17], !m1[17]};
                        cnt0_reg  <= a1;
                        cnt1_reg  <= a2;
                        err0_reg  <= ERR_W'(tot_c >> 1);
                        err1_reg  <= ERR_W'(tot_c >> 1);
                        done0_reg <= '0;
                        done1_reg <= '0;
                        tot_reg   <= tot_c;
                        idx_reg   <= '0;
                    end
                end
                S_DIV_RAMP:  if (alu_done) ramp_reg  <= ramp_c;
                S_DIV_MAX:   if (alu_done) maxd_reg  <= alu_res[HP_W-1:0];
                S_DIV_MIN:   if (alu_done) mind_reg  <= alu_res[HP_W-1:0];
                S_DIV_SLOPE:
                begin
                    if (alu_done)
                    begin
                        slope_reg  <= alu_res[HP_W-1:0];
                        moving_reg <= 1'b1;
                    end
                end
                S_MUL:
                begin
                    if (alu_done)
                    begin
                        err0_reg <= p0 ? e0 - ERR_W'(tot_reg) : e0;
                        err1_reg <= p1 ? e1 - ERR_W'(tot_reg) : e1;
                        if (p0) done0_reg <= done0_reg + CNT_W'(1);
                        if (p1) done1_reg <= done1_reg + CNT_W'(1);
                        idx_reg <= idx_inc;
                        if (idx_inc >= tot_reg)
                        begin
                            px_reg     <= tx_reg;
                            py_reg     <= ty_reg;
                            moving_reg <= 1'b0;
                        end
                    end
                end
                S_EMIT: ovalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= s_axis_tuser;
            dx_reg    <= s_axis_tdata[16:0];
            dy_reg    <= s_axis_tdata[33:17];
            speed_reg <= s_axis_tdata[49:34];
            limit_reg <= s_axis_tdata[50];
            abort_reg <= s_axis_tdata[51];
        end
        if (state_reg == S_PLAN)
            prod_reg <= 32'(speed_c) * 32'(spr_reg);
        unique case (state_reg)
            S_DECODE:
            begin
                up_reg       <= in_up;
                res_mask_reg <= '0;
                res_hp_reg   <= '0;
                if (!moving_reg)
                    res_st_reg <= ST_IDLE;
                else if (abort_reg)
                    res_st_reg <= ST_ABORTED;
                else
                    res_st_reg <= ST_LIMIT;
            end
            S_PLAN:      res_st_reg <= at_limit ? ST_AT_LIMIT : ST_STARTED;
            S_MUL:
            begin
                if (alu_done)
                begin
                    res_mask_reg <= {p1, p0};
                    res_hp_reg   <= hp_c;
                    res_st_reg   <= (idx_inc >= tot_reg) ? ST_DONE : ST_STEPPING;
                end
            end
            S_EMIT:
                odata_reg <= {res_st_reg, py_reg, px_reg, res_hp_reg,
                              dirs_reg[1], dirs_reg[0], res_mask_reg};
            default: ;
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    a_moving_total: assert property (@(posedge clk) disable iff (!rst_n)
        moving_reg |-> (tot_reg != '0 && idx_reg < tot_reg))
        else $error("move past its end");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == S_IDLE) else $error("ready while busy");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> !ovalid_reg) else $error("result overwritten");
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(moving_reg) |-> (tx_reg != px_reg || ty_reg != py_reg))
        else $error("move started at target");

endmodule
